>>> src/integer_to_decimal_ascii_macros.svh
// assertion macros for the decimal ascii converter
// used by integer_to_decimal_ascii; expects clk and rst_n in scope
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`ifndef ASSERT_OFF
`define ITDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITDA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ITDA_ASSERT(lbl, prop, msg)
`define ITDA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/itda_pkg.sv
// shared types and constants for the decimal ascii converter
// no dependencies
`default_nettype none
package itda_pkg;

    localparam int NumDigits = 20;
    localparam int MagWidth  = 64;
    localparam int BitCntW   = $clog2(MagWidth);
    localparam int DigCntW   = $clog2(NumDigits + 1);

    localparam logic [7:0] MinSize32 = 8'd12;
    localparam logic [7:0] MinSize64 = 8'd21;

    localparam logic [7:0] AsciiZero  = 8'h30;
    localparam logic [7:0] AsciiMinus = 8'h2D;
    localparam logic [7:0] AsciiNul   = 8'h00;

    localparam logic [1:0] KindU32 = 2'd0;
    localparam logic [1:0] KindS32 = 2'd1;
    localparam logic [1:0] KindU64 = 2'd2;
    localparam logic [1:0] KindS64 = 2'd3;

    localparam logic [31:0] MinNeg32 = 32'h8000_0000;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/itda_cell.sv
// one bcd digit cell of the double-dabble chain
// depends on itda_pkg
`default_nettype none
module itda_cell (
    input  wire logic                 clk,
    input  wire itda_pkg::cell_ctrl_t ctrl,
    input  wire logic                 bit_in,
    input  wire logic [3:0]           digit_in,
    output logic                      bit_out,
    output logic [3:0]                digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = adj[3];
    assign digit   = digit_reg;

endmodule
`default_nettype wire

>>> src/integer_to_decimal_ascii.sv
// a request that prints digits keeps busy high while it converts and emits;
// the 64-bit magnitude shifts one bit a cycle through the row of 20 bcd cells,
// then up to 19 leading zeros are dropped and one character leaves per cycle.
// a lone terminator or '-' and terminator are sent without conversion; size 0 gives nothing.
// throughput: one transaction per busy period; results cannot be stalled.
// reset clears the controller, the result strobe and the last flag; digit cells need no reset.
`default_nettype none
`include "integer_to_decimal_ascii_macros.svh"
module integer_to_decimal_ascii (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [63:0] value,
    input  wire logic [7:0]  dest_size,
    output logic             strobe,
    output logic [7:0]       char_out,
    output logic             last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONV   = 3'd1;
    localparam logic [2:0] S_SKIP   = 3'd2;
    localparam logic [2:0] S_DIGITS = 3'd3;
    localparam logic [2:0] S_NUL    = 3'd4;

    localparam int N = itda_pkg::NumDigits;

    logic [2:0]                     state_reg, state_next;
    logic [itda_pkg::BitCntW-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [itda_pkg::DigCntW-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [itda_pkg::MagWidth-1:0]  mag_reg, mag_next;
    logic                           strobe_reg, strobe_next;
    logic                           last_reg, last_next;
    logic [7:0]                     char_reg, char_next;

    logic                           accept;
    logic [31:0]                    low;
    logic                           neg;
    logic [itda_pkg::MagWidth-1:0]  mag_in;
    logic [7:0]                     min_size;
    logic                           emit_minus;
    logic                           emit_digits;

    itda_pkg::cell_ctrl_t           ctrl;
    logic [N:0]                     bit_chain;
    logic [N-1:0][3:0]              digit_chain;
    logic [3:0]                     top_digit;

    assign accept = start && !busy;
    assign low    = value[31:0];

    // sign, magnitude and minimum buffer size of the request
    always_comb
    begin
        neg      = 1'b0;
        mag_in   = {32'd0, low};
        min_size = itda_pkg::MinSize32;
        unique case (kind)
            itda_pkg::KindU32:
            begin
                neg = 1'b0;
            end
            itda_pkg::KindS32:
            begin
                if (low[31])
                begin
                    neg    = 1'b1;
                    mag_in = {32'd0, (~low) + 32'd1};
                    if (low == itda_pkg::MinNeg32)
                    begin
                        min_size = itda_pkg::MinSize64;
                    end
                end
            end
            itda_pkg::KindU64:
            begin
                mag_in   = value;
                min_size = itda_pkg::MinSize64;
            end
            itda_pkg::KindS64:
            begin
                neg      = value[63];
                mag_in   = value[63] ? (~value) + 64'd1 : value;
                min_size = itda_pkg::MinSize64;
            end
            default:
            begin
                neg = 1'b0;
            end
        endcase
        emit_minus  = neg && (dest_size > 8'd1);
        emit_digits = neg ? ({1'b0, dest_size} >= ({1'b0, min_size} + 9'd1))
                          : (dest_size >= min_size);
    end

    // digit cell row
    assign bit_chain[0] = mag_reg[itda_pkg::MagWidth-1];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [3:0] din;
        if (i == 0)
        begin : g_first
            assign din = 4'd0;
        end
        else
        begin : g_rest
            assign din = digit_chain[i-1];
        end
        itda_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .bit_in   (bit_chain[i]),
            .digit_in (din),
            .bit_out  (bit_chain[i+1]),
            .digit    (digit_chain[i])
        );
    end

    assign top_digit = digit_chain[N-1];

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        mag_next     = mag_reg;
        strobe_next  = 1'b0;
        last_next    = 1'b0;
        char_next    = char_reg;
        ctrl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (dest_size != 8'd0))
                begin
                    ctrl.clear   = 1'b1;
                    mag_next     = mag_in;
                    bit_cnt_next = '0;
                    state_next   = emit_digits ? S_CONV : S_NUL;
                    if (emit_minus)
                    begin
                        strobe_next = 1'b1;
                        char_next   = itda_pkg::AsciiMinus;
                    end
                end
            end
            S_CONV:
            begin
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[itda_pkg::MagWidth-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == itda_pkg::BitCntW'(itda_pkg::MagWidth - 1))
                begin
                    dig_cnt_next = itda_pkg::DigCntW'(N);
                    state_next   = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if ((top_digit == 4'd0) && (dig_cnt_reg > itda_pkg::DigCntW'(1)))
                begin
                    ctrl.shift   = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DIGITS;
                end
            end
            S_DIGITS:
            begin
                ctrl.shift   = 1'b1;
                strobe_next  = 1'b1;
                char_next    = itda_pkg::AsciiZero + {4'd0, top_digit};
                dig_cnt_next = dig_cnt_reg - 1'b1;
                if (dig_cnt_reg == itda_pkg::DigCntW'(1))
                begin
                    state_next = S_NUL;
                end
            end
            S_NUL:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                char_next   = itda_pkg::AsciiNul;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        mag_reg     <= mag_next;
        char_reg    <= char_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign char_out = char_reg;
    assign last     = last_reg;

    // no carry may leave the most significant digit cell
    `ITDA_ASSERT_NEVER(a_no_overflow, (state_reg == S_CONV) && bit_chain[N], "bcd overflow")
    // a non-empty transaction makes the block busy
    `ITDA_ASSERT(a_busy_start, (start && !busy && (dest_size != 8'd0)) |=> busy, "not busy")
    // the digit count never runs out while digits are pending
    `ITDA_ASSERT_NEVER(a_dig_cnt, ((state_reg == S_SKIP) || (state_reg == S_DIGITS)) && (dig_cnt_reg == '0), "digit count empty")

endmodule
`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for integer_to_decimal_ascii, the decimal text converter
// predicts every character of each request and compares it with the emitted stream
// depends on itda_pkg and the integer_to_decimal_ascii rtl
`default_nettype none
module testbench;

    localparam int StallLimit     = 2000;
    localparam int DrainCycles    = 120;
    localparam int RandomRequests = 400;
    localparam int QuietTail      = 80;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_char_t;

    class ascii_scoreboard;
        text_char_t expected_text[$];
        int mismatches;
        int requests;
        int chars_checked;

        function new();
            mismatches    = 0;
            requests      = 0;
            chars_checked = 0;
        endfunction

        function void push_char(logic [7:0] ch, logic fin);
            text_char_t c;
            c.ch  = ch;
            c.fin = fin;
            expected_text.push_back(c);
        endfunction

        function void push_magnitude(logic [63:0] mag, logic [7:0] size, logic [7:0] min_size);
            logic [7:0]  digits [20];
            logic [63:0] rest;
            int          count;
            rest  = mag;
            count = 0;
            if (size < min_size)
            begin
                push_char(itda_pkg::AsciiNul, 1'b1);
                return;
            end
            if (rest == 64'd0)
                push_char(itda_pkg::AsciiZero, 1'b0);
            while (rest != 64'd0)
            begin
                digits[count] = itda_pkg::AsciiZero + 8'(rest % 64'd10);
                rest = rest / 64'd10;
                count++;
            end
            for (int i = count - 1; i >= 0; i--)
                push_char(digits[i], 1'b0);
            push_char(itda_pkg::AsciiNul, 1'b1);
        endfunction

        function void push_negative(logic [63:0] mag, logic [7:0] size, logic [7:0] min_size);
            if (size <= 8'd1)
                push_char(itda_pkg::AsciiNul, 1'b1);
            else
            begin
                push_char(itda_pkg::AsciiMinus, 1'b0);
                push_magnitude(mag, size - 8'd1, min_size);
            end
        endfunction

        // note an accepted transaction and queue the text it must produce
        function void note_request(logic [1:0] k, logic [63:0] v, logic [7:0] size);
            logic [31:0] low;
            low = v[31:0];
            requests++;
            if (size == 8'd0)
                return;
            case (k)
                itda_pkg::KindU32:
                    push_magnitude({32'd0, low}, size, itda_pkg::MinSize32);
                itda_pkg::KindS32:
                begin
                    if (low == itda_pkg::MinNeg32)
                        push_negative({32'd0, itda_pkg::MinNeg32}, size, itda_pkg::MinSize64);
                    else if (low[31])
                        push_negative(64'h1_0000_0000 - {32'd0, low}, size, itda_pkg::MinSize32);
                    else
                        push_magnitude({32'd0, low}, size, itda_pkg::MinSize32);
                end
                itda_pkg::KindU64:
                    push_magnitude(v, size, itda_pkg::MinSize64);
                default:
                begin
                    if (v[63])
                        push_negative(~v + 64'd1, size, itda_pkg::MinSize64);
                    else
                        push_magnitude(v, size, itda_pkg::MinSize64);
                end
            endcase
        endfunction

        function void check_char(logic [7:0] ch, logic fin);
            text_char_t want;
            chars_checked++;
            if (expected_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: char 0x%02h last %0d with nothing pending", ch, fin);
                return;
            end
            want = expected_text.pop_front();
            if (ch !== want.ch || fin !== want.fin)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected char 0x%02h last %0d, got char 0x%02h last %0d",
                             want.ch, want.fin, ch, fin);
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  kind      = itda_pkg::KindU32;
    logic [63:0] value     = 64'd0;
    logic [7:0]  dest_size = 8'd0;
    logic        busy;
    logic        strobe;
    logic [7:0]  char_out;
    logic        last;

    ascii_scoreboard sb = new();
    int stall_cycles = 0;

    integer_to_decimal_ascii u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .dest_size (dest_size),
        .strobe    (strobe),
        .char_out  (char_out),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_char(char_out, last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("timeout: no transaction for %0d cycles, %0d characters pending",
                     StallLimit, sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] k, logic [63:0] v, logic [7:0] size);
        start     <= 1'b1;
        kind      <= k;
        value     <= v;
        dest_size <= size;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(k, v, size);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] p;
        p = 64'd1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return {$urandom, $urandom};
            4:
                return 64'($urandom_range(0, 1000));
            5:
            begin
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                return p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            6:
                return 64'd0 - 64'($urandom_range(0, 1000));
            7:
                return {$urandom, 1'b1, 31'($urandom)};
            8:
            begin
                case ($urandom_range(0, 5))
                    0: return 64'd0;
                    1: return {32'($urandom), itda_pkg::MinNeg32};
                    2: return 64'h8000_0000_0000_0000;
                    3: return 64'hFFFF_FFFF_FFFF_FFFF;
                    4: return 64'h7FFF_FFFF_FFFF_FFFF;
                    default: return {32'($urandom), 32'h7FFF_FFFF};
                endcase
            end
            default:
                return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [7:0] random_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'($urandom_range(22, 255));
            6, 7:             return 8'($urandom_range(10, 23));
            8:                return 8'($urandom_range(0, 255));
            default:          return 8'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin
        bit quiet;
        quiet = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and short buffer cases
        send_request(itda_pkg::KindU32, 64'd0, 8'd12);
        send_request(itda_pkg::KindU32, 64'hFFFF_FFFF, 8'd12);
        send_request(itda_pkg::KindU32, 64'hA5A5_A5A5_0000_3039, 8'd11);
        send_request(itda_pkg::KindU32, 64'hFFFF_FFFF_0000_3039, 8'd255);
        send_request(itda_pkg::KindU32, 64'd7, 8'd0);
        send_request(itda_pkg::KindS32, 64'hFFFF_FFFF, 8'd13);
        send_request(itda_pkg::KindS32, {32'd0, itda_pkg::MinNeg32}, 8'd22);
        send_request(itda_pkg::KindS32, {32'hFFFF_FFFF, itda_pkg::MinNeg32}, 8'd21);
        send_request(itda_pkg::KindS32, {32'd0, itda_pkg::MinNeg32}, 8'd2);
        send_request(itda_pkg::KindS32, 64'hFFFF_FFFB, 8'd1);
        send_request(itda_pkg::KindS32, 64'hFFFF_FFFB, 8'd2);
        send_request(itda_pkg::KindS32, 64'h7FFF_FFFF, 8'd12);
        send_request(itda_pkg::KindS32, 64'h8000_0001, 8'd12);
        send_request(itda_pkg::KindS32, 64'h8000_0001, 8'd13);
        send_request(itda_pkg::KindU64, 64'hFFFF_FFFF_FFFF_FFFF, 8'd21);
        send_request(itda_pkg::KindU64, 64'hFFFF_FFFF_FFFF_FFFF, 8'd20);
        send_request(itda_pkg::KindU64, 64'd0, 8'd21);
        send_request(itda_pkg::KindS64, 64'h8000_0000_0000_0000, 8'd22);
        send_request(itda_pkg::KindS64, 64'h8000_0000_0000_0000, 8'd21);
        send_request(itda_pkg::KindS64, 64'hFFFF_FFFF_FFFF_FFFF, 8'd2);
        send_request(itda_pkg::KindS64, 64'hFFFF_FFFF_FFFF_FFFF, 8'd22);
        send_request(itda_pkg::KindS64, 64'h7FFF_FFFF_FFFF_FFFF, 8'd21);
        send_request(itda_pkg::KindS64, 64'hFFFF_FFFF_FFFF_FFF0, 8'd1);
        send_request(itda_pkg::KindS64, 64'hFFFF_FFFF_FFFF_FFF0, 8'd0);
        wait_for_drain();

        for (int n = 0; n < RandomRequests; n++)
        begin
            send_request(2'($urandom_range(0, 3)), random_value(), random_size());
            if ($urandom_range(0, 29) == 0)
                quiet = !quiet;
            if (n % 100 == 50 && n < RandomRequests - QuietTail)
                wait_for_drain();
            else if (n < RandomRequests - QuietTail && !quiet && $urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 14));
        end

        wait_for_drain();
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d requests of all four kinds with %0d characters checked",
                 sb.requests, sb.chars_checked);
        $display("%0d mismatches, %0d characters never emitted", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
